// File: rtl/core/gjksi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gjksi_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned EdgeW  = 26;
  localparam int unsigned AccW   = 52;

  // 0.9 in Q12.12, rounded up so that |x| < 0.9 becomes |x| < NineTenths
  localparam logic signed [EdgeW-1:0] NineTenths = 26'sd3687;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdAdd   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE  = 2'd0,
    VERDICT_HIT       = 2'd1,
    VERDICT_SEPARATED = 2'd2,
    VERDICT_GAVE_UP   = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    VU_OP_CROSS = 2'd0,
    VU_OP_DOT   = 2'd1,
    VU_OP_SQ    = 2'd2,
    VU_OP_FIT   = 2'd3
  } vu_op_e;

  typedef enum logic [1:0] {
    VU_IDLE = 2'd0,
    VU_MUL  = 2'd1,
    VU_FIT  = 2'd2
  } vu_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_FIT,
    ST_START_SQ,
    ST_ADD_DOT,
    ST_LINE_DOT,
    ST_LINE_C1,
    ST_LINE_C2,
    ST_LINE_SQ,
    ST_LINE_FB,
    ST_LINE_AO,
    ST_TRI_N,
    ST_TRI_C1,
    ST_TRI_D1,
    ST_TRI_D2,
    ST_TRI_C2,
    ST_TRI_D3,
    ST_TRI_D4,
    ST_TRI_NEG,
    ST_TET_N,
    ST_TET_OPP,
    ST_TET_NEG,
    ST_TET_D,
    ST_FIN_SQ,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec24_t;

  typedef struct packed {
    logic signed [EdgeW-1:0] x;
    logic signed [EdgeW-1:0] y;
    logic signed [EdgeW-1:0] z;
  } vec26_t;

  typedef struct packed {
    logic   start;
    vu_op_e op;
  } vu_req_t;

  typedef struct packed {
    logic done;
    logic dot_pos;
    logic dot_neg;
    logic small_len;
  } vu_rsp_t;

  function automatic vec26_t ext(input vec24_t v);
    vec26_t r;
    r.x = {{2{v.x[23]}}, v.x};
    r.y = {{2{v.y[23]}}, v.y};
    r.z = {{2{v.z[23]}}, v.z};
    return r;
  endfunction

  function automatic vec26_t neg(input vec26_t v);
    vec26_t r;
    r.x = -v.x;
    r.y = -v.y;
    r.z = -v.z;
    return r;
  endfunction

  function automatic vec26_t sub(input vec24_t a, input vec24_t b);
    vec26_t r;
    vec26_t ea;
    vec26_t eb;
    ea = ext(a);
    eb = ext(b);
    r.x = ea.x - eb.x;
    r.y = ea.y - eb.y;
    r.z = ea.z - eb.z;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gjksi_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gjksi_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;
  modport source (output valid, command, point_x, point_y, point_z, input ready);
  modport sink   (input valid, command, point_x, point_y, point_z, output ready);
endinterface

interface gjksi_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic signed [23:0] dir_x;
  logic signed [23:0] dir_y;
  logic signed [23:0] dir_z;
  logic [2:0]  simplex_size;
  modport source (output valid, verdict, dir_x, dir_y, dir_z, simplex_size, input ready);
  modport sink   (input valid, verdict, dir_x, dir_y, dir_z, simplex_size, output ready);
endinterface

interface gjksi_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gjksi_vec_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module gjksi_vec_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  gjksi_pkg::vu_req_t    req_i,
  input  gjksi_pkg::vec26_t     opa_i,
  input  gjksi_pkg::vec26_t     opb_i,
  input  wire logic [23:0]      thr_i,
  output gjksi_pkg::vu_rsp_t    rsp_o,
  output gjksi_pkg::vec24_t     res_o
);

  gjksi_pkg::vu_state_e state_q, state_d;
  gjksi_pkg::vu_op_e    op_q;
  logic [2:0]           cnt_q;
  logic [2:0]           pidx_q;
  logic                 pv_q;
  logic                 done_q;
  logic signed [51:0]   prod_q;
  logic signed [51:0]   acc_q [3];

  logic [2:0]           nprod;
  logic signed [25:0]   mul_a, mul_b;
  logic signed [51:0]   product;
  logic [1:0]           aidx;
  logic                 all_fit;
  logic                 mul_end;
  logic                 finish;

  function automatic logic fits(input logic signed [51:0] v);
    return (v[51:23] == '0) || (v[51:23] == '1);
  endfunction

  assign nprod   = (op_q == gjksi_pkg::VU_OP_CROSS) ? 3'd6 : 3'd3;
  assign all_fit = fits(acc_q[0]) && fits(acc_q[1]) && fits(acc_q[2]);
  assign mul_end = (cnt_q == nprod) && !pv_q;
  assign aidx    = (op_q == gjksi_pkg::VU_OP_CROSS) ? pidx_q[2:1] : 2'd0;
  assign product = mul_a * mul_b;

  // operand pairs per product step
  always_comb begin
    mul_a = opa_i.x;
    mul_b = opb_i.x;
    case (op_q)
      gjksi_pkg::VU_OP_CROSS: begin
        case (cnt_q)
          3'd0:    begin mul_a = opa_i.y; mul_b = opb_i.z; end
          3'd1:    begin mul_a = opa_i.z; mul_b = opb_i.y; end
          3'd2:    begin mul_a = opa_i.z; mul_b = opb_i.x; end
          3'd3:    begin mul_a = opa_i.x; mul_b = opb_i.z; end
          3'd4:    begin mul_a = opa_i.x; mul_b = opb_i.y; end
          default: begin mul_a = opa_i.y; mul_b = opb_i.x; end
        endcase
      end
      gjksi_pkg::VU_OP_SQ: begin
        case (cnt_q)
          3'd0:    begin mul_a = opa_i.x; mul_b = opa_i.x; end
          3'd1:    begin mul_a = opa_i.y; mul_b = opa_i.y; end
          default: begin mul_a = opa_i.z; mul_b = opa_i.z; end
        endcase
      end
      default: begin
        case (cnt_q)
          3'd0:    begin mul_a = opa_i.x; mul_b = opb_i.x; end
          3'd1:    begin mul_a = opa_i.y; mul_b = opb_i.y; end
          default: begin mul_a = opa_i.z; mul_b = opb_i.z; end
        endcase
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gjksi_pkg::VU_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.op == gjksi_pkg::VU_OP_FIT) ? gjksi_pkg::VU_FIT : gjksi_pkg::VU_MUL;
        end
      end
      gjksi_pkg::VU_MUL: begin
        if (mul_end) begin
          state_d = (op_q == gjksi_pkg::VU_OP_CROSS) ? gjksi_pkg::VU_FIT : gjksi_pkg::VU_IDLE;
        end
      end
      gjksi_pkg::VU_FIT: begin
        if (all_fit) begin
          state_d = gjksi_pkg::VU_IDLE;
        end
      end
      default: state_d = gjksi_pkg::VU_IDLE;
    endcase
  end

  always_comb begin
    finish = 1'b0;
    case (state_q)
      gjksi_pkg::VU_MUL: finish = mul_end && (op_q != gjksi_pkg::VU_OP_CROSS);
      gjksi_pkg::VU_FIT: finish = all_fit;
      default:           finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gjksi_pkg::VU_IDLE;
      op_q    <= gjksi_pkg::VU_OP_CROSS;
      cnt_q   <= 3'd0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
      case (state_q)
        gjksi_pkg::VU_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            cnt_q <= 3'd0;
            pv_q  <= 1'b0;
          end
        end
        gjksi_pkg::VU_MUL: begin
          if (cnt_q != nprod) begin
            cnt_q <= cnt_q + 3'd1;
            pv_q  <= 1'b1;
          end else begin
            pv_q <= 1'b0;
          end
        end
        default: pv_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gjksi_pkg::VU_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == gjksi_pkg::VU_OP_FIT) begin
            acc_q[0] <= {{26{opa_i.x[25]}}, opa_i.x};
            acc_q[1] <= {{26{opa_i.y[25]}}, opa_i.y};
            acc_q[2] <= {{26{opa_i.z[25]}}, opa_i.z};
          end else begin
            acc_q[0] <= '0;
            acc_q[1] <= '0;
            acc_q[2] <= '0;
          end
        end
      end
      gjksi_pkg::VU_MUL: begin
        if (cnt_q != nprod) begin
          prod_q <= product;
          pidx_q <= cnt_q;
        end
        if (pv_q) begin
          // odd cross steps are the subtracted half of each component
          if ((op_q == gjksi_pkg::VU_OP_CROSS) && pidx_q[0]) begin
            acc_q[aidx] <= acc_q[aidx] - prod_q;
          end else begin
            acc_q[aidx] <= acc_q[aidx] + prod_q;
          end
        end
      end
      gjksi_pkg::VU_FIT: begin
        if (!all_fit) begin
          acc_q[0] <= acc_q[0] >>> 1;
          acc_q[1] <= acc_q[1] >>> 1;
          acc_q[2] <= acc_q[2] >>> 1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.dot_pos   = !acc_q[0][51] && (acc_q[0] != '0);
  assign rsp_o.dot_neg   = acc_q[0][51];
  assign rsp_o.small_len = $unsigned(acc_q[0]) <= {28'd0, thr_i};
  assign res_o.x         = acc_q[0][23:0];
  assign res_o.y         = acc_q[1][23:0];
  assign res_o.z         = acc_q[2][23:0];

endmodule

`default_nettype wire

// File: rtl/core/gjk_simplex_intersection_core.sv
`timescale 1ns / 1ps
`default_nettype none

// GJK intersection test over a host-supplied stream of Minkowski support points.
// item_i carries one transaction per command: start seeds the simplex with the
// point, add pushes the next support point taken along the last returned dir.
// result_o returns one transaction per item: verdict, next direction (zero on
// any final verdict) and the number of simplex points kept.
// cfg_i writes zero_threshold (reset 1), the squared length treated as zero;
// it is always ready and must only be written while the core is idle.
// Datapath: every vector operation runs on one 26x26 multiplier with a register
// after it; a cross product then halves its result until every component fits
// in 24 bits. An add ends after its first dot product when separated and runs
// longest on a full tetrahedron walk; one item is in flight at a time and
// item_i is ready only when the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it there and
// the core may accept and work on the next item, stopping before it writes
// the next result. Reset clears the simplex, the search state and the counts.
module gjk_simplex_intersection_core #(
  parameter int unsigned MAX_ADDS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  gjksi_item_if.sink         item_i,
  gjksi_result_if.source     result_o,
  gjksi_cfg_if.sink          cfg_i
);

  localparam int unsigned AddW = $clog2(MAX_ADDS + 1);

  gjksi_pkg::ctrl_state_e state_q, state_d;
  gjksi_pkg::verdict_e    verdict_q;
  gjksi_pkg::vec24_t      s_q [4];
  gjksi_pkg::vec24_t      p_q, dir_q, t_q, n_q;
  logic [2:0]             count_q;
  logic [AddW-1:0]        addc_q;
  logic [1:0]             face_q;
  logic                   chk_q;
  logic                   active_q;
  logic                   issued_q;
  logic [23:0]            thr_q;

  logic                   out_valid_q;
  gjksi_pkg::verdict_e    out_verdict_q;
  gjksi_pkg::vec24_t      out_dir_q;
  logic [2:0]             out_size_q;

  gjksi_pkg::vu_req_t     req;
  gjksi_pkg::vu_rsp_t     rsp;
  gjksi_pkg::vec26_t      opa, opb;
  gjksi_pkg::vec24_t      res;
  gjksi_pkg::vec26_t      ab, ac, ad, ao, fb, fu, fv, fo;
  gjksi_pkg::vec24_t      in_pt;
  logic signed [25:0]     abs_abx;
  logic                   in_acc, out_load, compute;
  logic [2:0]             cm;

  assign in_pt.x = item_i.point_x;
  assign in_pt.y = item_i.point_y;
  assign in_pt.z = item_i.point_z;
  assign in_acc  = item_i.valid && item_i.ready;
  assign out_load = (state_q == gjksi_pkg::ST_DONE) && (!out_valid_q || result_o.ready);
  assign cm       = (count_q > 3'd3) ? 3'd3 : count_q;

  assign ab  = gjksi_pkg::sub(s_q[1], s_q[0]);
  assign ac  = gjksi_pkg::sub(s_q[2], s_q[0]);
  assign ad  = gjksi_pkg::sub(s_q[3], s_q[0]);
  assign ao  = gjksi_pkg::neg(gjksi_pkg::ext(s_q[0]));
  assign abs_abx = ab.x[25] ? -ab.x : ab.x;

  // degenerate line: any vector perpendicular to the edge
  always_comb begin
    if (abs_abx < gjksi_pkg::NineTenths) begin
      fb.x = '0;
      fb.y = ab.z;
      fb.z = -ab.y;
    end else begin
      fb.x = -ab.z;
      fb.y = '0;
      fb.z = ab.x;
    end
  end

  // tetrahedron face under test and the vertex opposite to it
  always_comb begin
    case (face_q)
      2'd0:    begin fu = ab; fv = ac; fo = ad; end
      2'd1:    begin fu = ac; fv = ad; fo = ab; end
      default: begin fu = ad; fv = ab; fo = ac; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gjksi_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (item_i.command == gjksi_pkg::CmdStart) begin
            state_d = gjksi_pkg::ST_START_FIT;
          end else if (!active_q) begin
            state_d = gjksi_pkg::ST_DONE;
          end else begin
            state_d = gjksi_pkg::ST_ADD_DOT;
          end
        end
      end
      gjksi_pkg::ST_DONE: begin
        if (out_load) state_d = gjksi_pkg::ST_IDLE;
      end
      default: begin
        if (rsp.done) begin
          case (state_q)
            gjksi_pkg::ST_START_FIT: state_d = gjksi_pkg::ST_START_SQ;
            gjksi_pkg::ST_START_SQ:  state_d = gjksi_pkg::ST_DONE;
            gjksi_pkg::ST_ADD_DOT: begin
              if (rsp.dot_neg)       state_d = gjksi_pkg::ST_DONE;
              else if (cm == 3'd1)   state_d = gjksi_pkg::ST_LINE_DOT;
              else if (cm == 3'd2)   state_d = gjksi_pkg::ST_TRI_N;
              else                   state_d = gjksi_pkg::ST_TET_N;
            end
            gjksi_pkg::ST_LINE_DOT:
              state_d = rsp.dot_pos ? gjksi_pkg::ST_LINE_C1 : gjksi_pkg::ST_LINE_AO;
            gjksi_pkg::ST_LINE_C1: state_d = gjksi_pkg::ST_LINE_C2;
            gjksi_pkg::ST_LINE_C2:
              state_d = chk_q ? gjksi_pkg::ST_LINE_SQ : gjksi_pkg::ST_FIN_SQ;
            gjksi_pkg::ST_LINE_SQ:
              state_d = rsp.small_len ? gjksi_pkg::ST_LINE_FB : gjksi_pkg::ST_FIN_SQ;
            gjksi_pkg::ST_LINE_FB: state_d = gjksi_pkg::ST_FIN_SQ;
            gjksi_pkg::ST_LINE_AO: state_d = gjksi_pkg::ST_FIN_SQ;
            gjksi_pkg::ST_TRI_N:   state_d = gjksi_pkg::ST_TRI_C1;
            gjksi_pkg::ST_TRI_C1:  state_d = gjksi_pkg::ST_TRI_D1;
            gjksi_pkg::ST_TRI_D1:
              state_d = rsp.dot_pos ? gjksi_pkg::ST_TRI_D2 : gjksi_pkg::ST_TRI_C2;
            gjksi_pkg::ST_TRI_D2:
              state_d = rsp.dot_pos ? gjksi_pkg::ST_LINE_C1 : gjksi_pkg::ST_LINE_DOT;
            gjksi_pkg::ST_TRI_C2:  state_d = gjksi_pkg::ST_TRI_D3;
            gjksi_pkg::ST_TRI_D3:
              state_d = rsp.dot_pos ? gjksi_pkg::ST_LINE_DOT : gjksi_pkg::ST_TRI_D4;
            gjksi_pkg::ST_TRI_D4:
              state_d = rsp.dot_pos ? gjksi_pkg::ST_FIN_SQ : gjksi_pkg::ST_TRI_NEG;
            gjksi_pkg::ST_TRI_NEG: state_d = gjksi_pkg::ST_FIN_SQ;
            gjksi_pkg::ST_TET_N:   state_d = gjksi_pkg::ST_TET_OPP;
            gjksi_pkg::ST_TET_OPP:
              state_d = rsp.dot_pos ? gjksi_pkg::ST_TET_NEG : gjksi_pkg::ST_TET_D;
            gjksi_pkg::ST_TET_NEG: state_d = gjksi_pkg::ST_TET_D;
            gjksi_pkg::ST_TET_D: begin
              if (rsp.dot_pos)           state_d = gjksi_pkg::ST_TRI_N;
              else if (face_q != 2'd2)   state_d = gjksi_pkg::ST_TET_N;
              else                       state_d = gjksi_pkg::ST_DONE;
            end
            gjksi_pkg::ST_FIN_SQ:  state_d = gjksi_pkg::ST_DONE;
            default:               state_d = gjksi_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  // operation and operands for the shared vector unit
  always_comb begin
    compute = 1'b1;
    req.op  = gjksi_pkg::VU_OP_DOT;
    opa     = ab;
    opb     = ao;
    case (state_q)
      gjksi_pkg::ST_START_FIT: begin
        req.op = gjksi_pkg::VU_OP_FIT; opa = gjksi_pkg::neg(gjksi_pkg::ext(p_q));
      end
      gjksi_pkg::ST_START_SQ: begin
        req.op = gjksi_pkg::VU_OP_SQ; opa = gjksi_pkg::ext(t_q);
      end
      gjksi_pkg::ST_ADD_DOT: begin
        opa = gjksi_pkg::ext(p_q); opb = gjksi_pkg::ext(dir_q);
      end
      gjksi_pkg::ST_LINE_DOT: begin
        opa = ab; opb = ao;
      end
      gjksi_pkg::ST_LINE_C1: begin
        req.op = gjksi_pkg::VU_OP_CROSS; opa = ab; opb = ao;
      end
      gjksi_pkg::ST_LINE_C2: begin
        req.op = gjksi_pkg::VU_OP_CROSS; opa = gjksi_pkg::ext(t_q); opb = ab;
      end
      gjksi_pkg::ST_LINE_SQ, gjksi_pkg::ST_FIN_SQ: begin
        req.op = gjksi_pkg::VU_OP_SQ; opa = gjksi_pkg::ext(dir_q);
      end
      gjksi_pkg::ST_LINE_FB: begin
        req.op = gjksi_pkg::VU_OP_FIT; opa = fb;
      end
      gjksi_pkg::ST_LINE_AO: begin
        req.op = gjksi_pkg::VU_OP_FIT; opa = ao;
      end
      gjksi_pkg::ST_TRI_N: begin
        req.op = gjksi_pkg::VU_OP_CROSS; opa = ab; opb = ac;
      end
      gjksi_pkg::ST_TRI_C1: begin
        req.op = gjksi_pkg::VU_OP_CROSS; opa = gjksi_pkg::ext(n_q); opb = ac;
      end
      gjksi_pkg::ST_TRI_D1, gjksi_pkg::ST_TRI_D3: begin
        opa = gjksi_pkg::ext(t_q); opb = ao;
      end
      gjksi_pkg::ST_TRI_D2: begin
        opa = ac; opb = ao;
      end
      gjksi_pkg::ST_TRI_C2: begin
        req.op = gjksi_pkg::VU_OP_CROSS; opa = ab; opb = gjksi_pkg::ext(n_q);
      end
      gjksi_pkg::ST_TRI_D4, gjksi_pkg::ST_TET_D: begin
        opa = gjksi_pkg::ext(n_q); opb = ao;
      end
      gjksi_pkg::ST_TRI_NEG, gjksi_pkg::ST_TET_NEG: begin
        req.op = gjksi_pkg::VU_OP_FIT; opa = gjksi_pkg::neg(gjksi_pkg::ext(n_q));
      end
      gjksi_pkg::ST_TET_N: begin
        req.op = gjksi_pkg::VU_OP_CROSS; opa = fu; opb = fv;
      end
      gjksi_pkg::ST_TET_OPP: begin
        opa = gjksi_pkg::ext(n_q); opb = fo;
      end
      default: compute = 1'b0;
    endcase
    req.start = compute && !issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= gjksi_pkg::ST_IDLE;
      verdict_q     <= gjksi_pkg::VERDICT_CONTINUE;
      issued_q      <= 1'b0;
      active_q      <= 1'b0;
      count_q       <= 3'd0;
      addc_q        <= '0;
      face_q        <= 2'd0;
      chk_q         <= 1'b0;
      thr_q         <= 24'd1;
      out_valid_q   <= 1'b0;
      out_verdict_q <= gjksi_pkg::VERDICT_CONTINUE;
      out_dir_q     <= '0;
      out_size_q    <= 3'd0;
      dir_q         <= '0;
      for (int i = 0; i < 4; i++) s_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (req.start) begin
        issued_q <= 1'b1;
      end else if (rsp.done) begin
        issued_q <= 1'b0;
      end
      if (cfg_i.valid) thr_q <= cfg_i.data;

      if (out_load) begin
        out_valid_q   <= 1'b1;
        out_verdict_q <= verdict_q;
        out_dir_q     <= (verdict_q == gjksi_pkg::VERDICT_CONTINUE) ? dir_q : '0;
        out_size_q    <= count_q;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if ((state_q == gjksi_pkg::ST_IDLE) && in_acc) begin
        p_q       <= in_pt;
        verdict_q <= gjksi_pkg::VERDICT_CONTINUE;
        if (item_i.command == gjksi_pkg::CmdStart) begin
          s_q[0]  <= in_pt;
          count_q <= 3'd1;
          addc_q  <= '0;
        end else if (!active_q) begin
          verdict_q <= gjksi_pkg::VERDICT_SEPARATED;
        end else begin
          addc_q <= addc_q + 1'b1;
        end
      end

      if (rsp.done) begin
        case (state_q)
          gjksi_pkg::ST_START_FIT: begin
            t_q   <= res;
            dir_q <= res;
          end
          gjksi_pkg::ST_START_SQ: begin
            if (rsp.small_len) begin
              verdict_q <= gjksi_pkg::VERDICT_HIT;
              active_q  <= 1'b0;
            end else begin
              active_q <= 1'b1;
            end
          end
          gjksi_pkg::ST_ADD_DOT: begin
            if (rsp.dot_neg) begin
              verdict_q <= gjksi_pkg::VERDICT_SEPARATED;
              active_q  <= 1'b0;
              count_q   <= 3'd0;
            end else begin
              // push the new point as the newest vertex
              s_q[0] <= p_q;
              s_q[1] <= s_q[0];
              if (cm >= 3'd2) s_q[2] <= s_q[1];
              if (cm >= 3'd3) s_q[3] <= s_q[2];
              count_q <= cm + 3'd1;
              chk_q   <= 1'b1;
              face_q  <= 2'd0;
            end
          end
          gjksi_pkg::ST_LINE_DOT: begin
            if (!rsp.dot_pos) count_q <= 3'd1;
          end
          gjksi_pkg::ST_LINE_C1: t_q <= res;
          gjksi_pkg::ST_LINE_C2, gjksi_pkg::ST_LINE_FB, gjksi_pkg::ST_LINE_AO,
          gjksi_pkg::ST_TRI_NEG: dir_q <= res;
          gjksi_pkg::ST_TRI_N, gjksi_pkg::ST_TET_N, gjksi_pkg::ST_TET_NEG: n_q <= res;
          gjksi_pkg::ST_TRI_C1, gjksi_pkg::ST_TRI_C2: t_q <= res;
          gjksi_pkg::ST_TRI_D2: begin
            count_q <= 3'd2;
            if (rsp.dot_pos) begin
              s_q[1] <= s_q[2];
              chk_q  <= 1'b0;
            end
          end
          gjksi_pkg::ST_TRI_D3: begin
            if (rsp.dot_pos) count_q <= 3'd2;
          end
          gjksi_pkg::ST_TRI_D4: begin
            if (rsp.dot_pos) begin
              dir_q <= n_q;
            end else begin
              s_q[1] <= s_q[2];
              s_q[2] <= s_q[1];
            end
          end
          gjksi_pkg::ST_TET_D: begin
            if (rsp.dot_pos) begin
              count_q <= 3'd3;
              case (face_q)
                2'd0: ;
                2'd1: begin
                  s_q[1] <= s_q[2];
                  s_q[2] <= s_q[3];
                end
                default: begin
                  s_q[1] <= s_q[3];
                  s_q[2] <= s_q[1];
                end
              endcase
            end else if (face_q != 2'd2) begin
              face_q <= face_q + 2'd1;
            end else begin
              verdict_q <= gjksi_pkg::VERDICT_HIT;
              active_q  <= 1'b0;
            end
          end
          gjksi_pkg::ST_FIN_SQ: begin
            if (rsp.small_len) begin
              verdict_q <= gjksi_pkg::VERDICT_SEPARATED;
              active_q  <= 1'b0;
              count_q   <= 3'd0;
            end else if (addc_q >= AddW'(MAX_ADDS)) begin
              verdict_q <= gjksi_pkg::VERDICT_GAVE_UP;
              active_q  <= 1'b0;
              count_q   <= 3'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  gjksi_vec_unit u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .thr_i  (thr_q),
    .rsp_o  (rsp),
    .res_o  (res)
  );

  assign item_i.ready          = (state_q == gjksi_pkg::ST_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_valid_q;
  assign result_o.verdict      = out_verdict_q;
  assign result_o.dir_x        = out_dir_q.x;
  assign result_o.dir_y        = out_dir_q.y;
  assign result_o.dir_z        = out_dir_q.z;
  assign result_o.simplex_size = out_size_q;

endmodule

`default_nettype wire
